[rtl/despill_edge_cleanup_filter_macros.svh]
// Assertion macros for the despill filter RTL.
`ifndef DESPILL_EDGE_CLEANUP_FILTER_MACROS_SVH
`define DESPILL_EDGE_CLEANUP_FILTER_MACROS_SVH

// Check a property at every clock edge outside reset.
`define DECE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a cause is followed by an effect on the next clock.
`define DECE_ASSERT_NEXT(label, cause, effect, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) else $error(msg);

`endif

[rtl/dece_pkg.sv]
// Shared types, constants and tables of the despill filter.
`default_nettype none
package dece_pkg;

  localparam int MAX_WIDTH     = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int WINDOW_RADIUS = 2;
  localparam int WIN           = 2 * WINDOW_RADIUS + 1;
  localparam int LINES         = WIN - 1;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WW    = 11;
  localparam int HW    = 13;
  localparam int TOL_W = 7;
  localparam int POS_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 2);
  localparam int CNT_W = 23;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam int DIST_W = 18;
  localparam int LIM_W  = 19;
  localparam logic [7:0] OPAQUE_MIN = 8'd128;
  localparam longint unsigned SCALE_NUM  = 44167;
  localparam longint unsigned SCALE_DEN2 = 100000000;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam int ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_FRINGE_RED   = 3'd0,
    REG_FRINGE_GREEN = 3'd1,
    REG_FRINGE_BLUE  = 3'd2,
    REG_TOLERANCE    = 3'd3,
    REG_DESPILL_MODE = 3'd4,
    REG_IMAGE_WIDTH  = 3'd5,
    REG_IMAGE_HEIGHT = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] pix_alpha;
    logic [7:0] pix_red;
    logic [7:0] pix_green;
    logic [7:0] pix_blue;
    logic       in_region;
    logic       flush;
  } pix_t;

  typedef struct packed {
    logic [7:0]       out_alpha;
    logic [7:0]       out_red;
    logic [7:0]       out_green;
    logic [7:0]       out_blue;
    logic             changed;
    logic             frame_end;
    logic [CNT_W-1:0] modified_count;
  } res_t;

  typedef struct packed {
    logic       region;
    logic [7:0] a;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } entry_t;

  typedef entry_t [LINES-1:0] line_word_t;
  typedef entry_t [WIN-1:0][WIN-1:0] win_t;

  typedef struct packed {
    logic [WIN-1:0] col_ok;
    logic [WIN-1:0] row_ok;
    logic           frame_end;
  } pos_info_t;

  typedef struct packed {
    logic [7:0]       fr;
    logic [7:0]       fg;
    logic [7:0]       fb;
    logic             strict;
    logic [LIM_W-1:0] lim;
  } cfg_t;

  typedef struct packed {
    logic s0;
    logic s1;
  } occ_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       changed;
    logic       frame_end;
  } q_item_t;

  // Largest squared distance that still counts as fringe, per tolerance.
  typedef logic [LIM_W-1:0] lim_tab_t [2**TOL_W];

  function automatic lim_tab_t build_lim();
    lim_tab_t tab;
    longint unsigned t;
    for (int i = 0; i < 2**TOL_W; i++) begin
      t = longint'(i) * SCALE_NUM;
      tab[i] = LIM_W'((t * t) / SCALE_DEN2);
    end
    return tab;
  endfunction

  localparam lim_tab_t LIM_TAB = build_lim();

endpackage
`default_nettype wire

[rtl/despill_edge_cleanup_filter.sv]
// Top level of the despill and edge-cleanup filter.
// Throughput: one pixel beat per clock, sustained while results are taken.
// Latency: a pixel's result is produced 2*W+2 input beats after it (W = width),
//   then passes through store read, window, distance, row search, queue and output.
// Reset: synchronous; clears counters, queue, valid flags and configuration registers to their defaults.
// The line store is not cleared; rows outside the frame are masked by position.
`default_nettype none
module despill_edge_cleanup_filter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dece_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          pix_valid,
  output logic                          pix_ready,
  input  dece_pkg::pix_t                pix_data,
  output logic                          res_valid,
  input  logic                          res_ready,
  output dece_pkg::res_t                res_data
);
  import dece_pkg::*;

  // Configuration registers.
  logic [7:0]       fringe_red, fringe_green, fringe_blue;
  logic [TOL_W-1:0] tolerance;
  logic             despill_mode;
  logic [WW-1:0]    image_width;
  logic [HW-1:0]    image_height;
  logic [LIM_W-1:0] lim;
  reg_idx_t         widx;
  logic             wr_en;

  // Front, classification, queue and output wiring.
  logic      take;
  win_t      win;
  logic      win_valid;
  pos_info_t win_info;
  occ_t      front_occ, cls_occ;
  cfg_t      cfg;
  logic      push, pop;
  q_item_t   push_item, pop_item;
  logic [FIFO_CW-1:0] q_count;
  logic [FIFO_CW:0]   held;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign widx   = reg_idx_t'(paddr[4:2]);

  // Take a register write on the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      fringe_red   <= 8'd0;
      fringe_green <= 8'd255;
      fringe_blue  <= 8'd0;
      tolerance    <= TOL_W'(35);
      despill_mode <= 1'b0;
      image_width  <= WW'(1024);
      image_height <= HW'(4096);
    end else if (wr_en) begin
      case (widx)
        REG_FRINGE_RED:   fringe_red   <= pwdata[7:0];
        REG_FRINGE_GREEN: fringe_green <= pwdata[7:0];
        REG_FRINGE_BLUE:  fringe_blue  <= pwdata[7:0];
        REG_TOLERANCE:    tolerance    <= pwdata[TOL_W-1:0];
        REG_DESPILL_MODE: despill_mode <= pwdata[0];
        REG_IMAGE_WIDTH:  image_width  <= pwdata[WW-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[HW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_FRINGE_RED:   prdata = 32'(fringe_red);
      REG_FRINGE_GREEN: prdata = 32'(fringe_green);
      REG_FRINGE_BLUE:  prdata = 32'(fringe_blue);
      REG_TOLERANCE:    prdata = 32'(tolerance);
      REG_DESPILL_MODE: prdata = 32'(despill_mode);
      REG_IMAGE_WIDTH:  prdata = 32'(image_width);
      REG_IMAGE_HEIGHT: prdata = 32'(image_height);
      default:          prdata = '0;
    endcase
  end

  // Distance limit for the tolerance: a squared distance at or below it is fringe.
  always_ff @(posedge clk) begin
    lim <= LIM_TAB[tolerance];
  end

  assign cfg = '{fr: fringe_red, fg: fringe_green, fb: fringe_blue,
                 strict: despill_mode, lim: lim};

  // Admit a beat only while the queue can hold everything already in flight.
  assign held = (FIFO_CW+1)'(q_count) + (FIFO_CW+1)'(front_occ.s0)
              + (FIFO_CW+1)'(front_occ.s1)
              + (FIFO_CW+1)'(cls_occ.s0) + (FIFO_CW+1)'(cls_occ.s1);
  assign pix_ready = !rst && (held < (FIFO_CW+1)'(FIFO_DEPTH));
  assign take      = pix_valid && pix_ready;

  dece_front u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .pix        (pix_data),
    .cfg_width  (image_width),
    .cfg_height (image_height),
    .win        (win),
    .win_valid  (win_valid),
    .win_info   (win_info),
    .occ        (front_occ)
  );

  dece_cls u_cls (
    .clk       (clk),
    .rst       (rst),
    .win       (win),
    .win_valid (win_valid),
    .win_info  (win_info),
    .cfg       (cfg),
    .push      (push),
    .push_item (push_item),
    .occ       (cls_occ)
  );

  dece_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .count     (q_count)
  );

  dece_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_count   (q_count),
    .q_item    (pop_item),
    .pop       (pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

endmodule
`default_nettype wire

[rtl/dece_front.sv]
// Intake: position counters, line store and the 5x5 window.
`default_nettype none
module dece_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  dece_pkg::pix_t       pix,
  input  logic [10:0]          cfg_width,
  input  logic [12:0]          cfg_height,
  output dece_pkg::win_t       win,
  output logic                 win_valid,
  output dece_pkg::pos_info_t  win_info,
  output dece_pkg::occ_t       occ
);
  import dece_pkg::*;

  logic [POS_W-1:0] item_pos;
  logic [POS_W-1:0] npix;
  logic [POS_W-1:0] delay;
  logic [WW-1:0]    frame_w;
  logic [HW-1:0]    frame_h;
  logic [COL_W-1:0] xk;
  logic [COL_W-1:0] ocx;
  logic [ROW_W-1:0] ocy;

  logic [WW-1:0] cw, cur_w;
  logic [HW-1:0] ch;
  logic          first, pix_phase, emit, fe;
  entry_t        e_in;
  pos_info_t     info_in;

  logic       a_valid, a_emit;
  entry_t     a_e;
  logic [COL_W-1:0] a_col;
  pos_info_t  a_info;

  line_word_t mem [MAX_WIDTH];
  line_word_t rd, byp_word, rd_eff, wd;
  logic       byp;

  function automatic logic [WW-1:0] clamp_w(logic [WW-1:0] v);
    if (v == '0) return WW'(1);
    if (v > WW'(MAX_WIDTH)) return WW'(MAX_WIDTH);
    return v;
  endfunction

  function automatic logic [HW-1:0] clamp_h(logic [HW-1:0] v);
    if (v == '0) return HW'(1);
    if (v > HW'(MAX_HEIGHT)) return HW'(MAX_HEIGHT);
    return v;
  endfunction

  always_comb begin
    cw        = clamp_w(cfg_width);
    ch        = clamp_h(cfg_height);
    first     = (item_pos == '0);
    cur_w     = first ? cw : frame_w;
    pix_phase = first || (item_pos < npix);
    emit      = !first && (item_pos >= delay);
    fe        = emit && (ocx == COL_W'(frame_w - WW'(1))) && (ocy == ROW_W'(frame_h - HW'(1)));
    if (pix_phase && !pix.flush) begin
      e_in = '{region: pix.in_region, a: pix.pix_alpha, r: pix.pix_red,
               g: pix.pix_green, b: pix.pix_blue};
    end else begin
      e_in = '0;
    end
    info_in.col_ok[0] = (ocx >= COL_W'(2));
    info_in.col_ok[1] = (ocx >= COL_W'(1));
    info_in.col_ok[2] = 1'b1;
    info_in.col_ok[3] = (WW'(ocx) + WW'(1)) < frame_w;
    info_in.col_ok[4] = (WW'(ocx) + WW'(2)) < frame_w;
    info_in.row_ok[0] = (ocy >= ROW_W'(2));
    info_in.row_ok[1] = (ocy >= ROW_W'(1));
    info_in.row_ok[2] = 1'b1;
    info_in.row_ok[3] = (HW'(ocy) + HW'(1)) < frame_h;
    info_in.row_ok[4] = (HW'(ocy) + HW'(2)) < frame_h;
    info_in.frame_end = fe;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_pos <= '0;
      xk       <= '0;
      ocx      <= '0;
      ocy      <= '0;
      frame_w  <= WW'(1);
      frame_h  <= HW'(1);
      npix     <= POS_W'(1);
      delay    <= POS_W'(4);
    end else if (take) begin
      if (first) begin
        frame_w <= cw;
        frame_h <= ch;
        npix    <= POS_W'(cw) * POS_W'(ch);
        delay   <= POS_W'({cw, 1'b0}) + POS_W'(2);
      end
      if (fe) begin
        item_pos <= '0;
        xk       <= '0;
        ocx      <= '0;
        ocy      <= '0;
      end else begin
        item_pos <= item_pos + POS_W'(1);
        xk       <= (xk == COL_W'(cur_w - WW'(1))) ? '0 : xk + COL_W'(1);
        if (emit) begin
          if (ocx == COL_W'(frame_w - WW'(1))) begin
            ocx <= '0;
            ocy <= ocy + ROW_W'(1);
          end else begin
            ocx <= ocx + COL_W'(1);
          end
        end
      end
    end
  end

  // Stage A: hold the beat while its column is read from the line store.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_e    <= e_in;
      a_col  <= xk;
      a_emit <= emit;
      a_info <= info_in;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid) begin
      mem[a_col] <= wd;
    end
    if (take) begin
      rd <= mem[xk];
    end
  end

  // Forward a write that lands in the same column as the read behind it.
  always_ff @(posedge clk) begin
    byp      <= take && a_valid && (a_col == xk);
    byp_word <= wd;
  end

  always_comb begin
    rd_eff = byp ? byp_word : rd;
    wd[0]  = a_e;
    for (int i = 1; i < LINES; i++) begin
      wd[i] = rd_eff[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid) begin
      for (int r = 0; r < WIN; r++) begin
        for (int j = 0; j < WIN - 1; j++) begin
          win[r][j] <= win[r][j+1];
        end
      end
      for (int r = 0; r < LINES; r++) begin
        win[r][WIN-1] <= rd_eff[LINES-1-r];
      end
      win[WIN-1][WIN-1] <= a_e;
      win_info <= a_info;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
    end else begin
      win_valid <= a_valid && a_emit;
    end
  end

  assign occ = '{s0: a_valid, s1: win_valid};

endmodule
`default_nettype wire

[rtl/dece_cls.sv]
// Classification: fringe test, neighbour distances and best-neighbour search.
`default_nettype none
module dece_cls (
  input  logic                clk,
  input  logic                rst,
  input  dece_pkg::win_t      win,
  input  logic                win_valid,
  input  dece_pkg::pos_info_t win_info,
  input  dece_pkg::cfg_t      cfg,
  output logic                push,
  output dece_pkg::q_item_t   push_item,
  output dece_pkg::occ_t      occ
);
  import dece_pkg::*;

  typedef struct packed {
    logic              v;
    logic [DIST_W-1:0] d;
    logic [23:0]       rgb;
  } cand_t;

  typedef cand_t [WIN-1:0][WIN-1:0] cand_grid_t;
  typedef cand_t [WIN-1:0] cand_row_t;

  function automatic logic [DIST_W-1:0] dist_sq(entry_t e, cfg_t c);
    logic signed [DIST_W-1:0] dr, dg, db;
    logic [DIST_W-1:0] sr, sg, sb;
    dr = $signed({1'b0, e.r}) - $signed({1'b0, c.fr});
    dg = $signed({1'b0, e.g}) - $signed({1'b0, c.fg});
    db = $signed({1'b0, e.b}) - $signed({1'b0, c.fb});
    sr = $unsigned(dr * dr);
    sg = $unsigned(dg * dg);
    sb = $unsigned(db * db);
    return sr + sg + sb;
  endfunction

  // Take the later valid candidate only when the earlier one is invalid or it is strictly farther.
  function automatic cand_t pick(cand_t a, cand_t b);
    if (b.v && (!a.v || (b.d > a.d))) return b;
    return a;
  endfunction

  cand_grid_t cand_in;
  logic       fringe_in, border;
  entry_t     p;

  logic       d_valid, d_fringe, d_fe;
  entry_t     d_p;
  cand_grid_t d_cand;

  cand_row_t  grp_in;
  logic       t_valid, t_fringe, t_fe;
  entry_t     t_p;
  cand_row_t  t_grp;
  cand_t      best;

  always_comb begin
    p = win[WINDOW_RADIUS][WINDOW_RADIUS];
    for (int r = 0; r < WIN; r++) begin
      for (int j = 0; j < WIN; j++) begin
        cand_in[r][j].v   = win_info.col_ok[j] && win_info.row_ok[r] &&
                            (win[r][j].a > OPAQUE_MIN) &&
                            !(r == WINDOW_RADIUS && j == WINDOW_RADIUS);
        cand_in[r][j].d   = dist_sq(win[r][j], cfg);
        cand_in[r][j].rgb = {win[r][j].r, win[r][j].g, win[r][j].b};
      end
    end
    border = !win_info.col_ok[1] || !win_info.col_ok[3] ||
             !win_info.row_ok[1] || !win_info.row_ok[3] ||
             (win[2][1].a == '0) || (win[2][3].a == '0) ||
             (win[1][2].a == '0) || (win[3][2].a == '0);
    fringe_in = p.region && (p.a != '0) && border &&
                (LIM_W'(cand_in[2][2].d) <= cfg.lim);
  end

  always_ff @(posedge clk) begin
    if (win_valid) begin
      d_cand   <= cand_in;
      d_p      <= p;
      d_fringe <= fringe_in;
      d_fe     <= win_info.frame_end;
    end
  end

  // First half of the search: best of each window row, in scan order.
  always_comb begin
    for (int r = 0; r < WIN; r++) begin
      grp_in[r] = d_cand[r][0];
      for (int j = 1; j < WIN; j++) begin
        grp_in[r] = pick(grp_in[r], d_cand[r][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (d_valid) begin
      t_grp    <= grp_in;
      t_p      <= d_p;
      t_fringe <= d_fringe;
      t_fe     <= d_fe;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
      t_valid <= 1'b0;
    end else begin
      d_valid <= win_valid;
      t_valid <= d_valid;
    end
  end

  always_comb begin
    best = t_grp[0];
    for (int r = 1; r < WIN; r++) begin
      best = pick(best, t_grp[r]);
    end
    push_item.changed   = t_fringe;
    push_item.frame_end = t_fe;
    if (!t_fringe) begin
      {push_item.a, push_item.r, push_item.g, push_item.b} = {t_p.a, t_p.r, t_p.g, t_p.b};
    end else if (!cfg.strict && best.v && (LIM_W'(best.d) > cfg.lim)) begin
      {push_item.a, push_item.r, push_item.g, push_item.b} = {t_p.a, best.rgb};
    end else begin
      {push_item.a, push_item.r, push_item.g, push_item.b} = '0;
    end
  end

  assign push = t_valid;
  assign occ  = '{s0: d_valid, s1: t_valid};

endmodule
`default_nettype wire

[rtl/dece_fifo.sv]
// Short queue between classification and output.
`default_nettype none
`include "despill_edge_cleanup_filter_macros.svh"
module dece_fifo (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  dece_pkg::q_item_t              push_item,
  input  logic                           pop,
  output dece_pkg::q_item_t              pop_item,
  output logic [dece_pkg::FIFO_CW-1:0]   count
);
  import dece_pkg::*;

  q_item_t            slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp, rp;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + FIFO_AW'(1);
      if (pop) rp <= rp + FIFO_AW'(1);
      if (push && !pop) begin
        count <= count + FIFO_CW'(1);
      end else if (pop && !push) begin
        count <= count - FIFO_CW'(1);
      end
    end
  end

  assign pop_item = slots[rp];

  `DECE_ASSERT(a_no_overflow, !(push && !pop && (count == FIFO_CW'(FIFO_DEPTH))), "queue overflow")
  `DECE_ASSERT(a_no_underflow, !(pop && (count == '0)), "queue underflow")
  `DECE_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + FIFO_CW'(1), "count slip")

endmodule
`default_nettype wire

[rtl/dece_back.sv]
// Output stage: result register and running modified count.
`default_nettype none
module dece_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [dece_pkg::FIFO_CW-1:0]  q_count,
  input  dece_pkg::q_item_t             q_item,
  output logic                          pop,
  output logic                          res_valid,
  input  logic                          res_ready,
  output dece_pkg::res_t                res_data
);
  import dece_pkg::*;

  logic [CNT_W-1:0] total, total_next;

  assign pop = (q_count != '0) && (!res_valid || res_ready);

  always_comb begin
    total_next = total;
    if (q_item.changed && (total != COUNT_MAX)) begin
      total_next = total + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      total     <= '0;
    end else if (pop) begin
      res_valid <= 1'b1;
      total     <= q_item.frame_end ? '0 : total_next;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_data <= '{out_alpha: q_item.a, out_red: q_item.r, out_green: q_item.g,
                    out_blue: q_item.b, changed: q_item.changed,
                    frame_end: q_item.frame_end, modified_count: total_next};
    end
  end

endmodule
`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for the despill and edge-cleanup filter: frames in, predicted pixels out.
`timescale 1ns / 100ps
module tb_top;
  import dece_pkg::*;

  localparam int RING     = 4 * MAX_WIDTH + 8;
  localparam int WATCHDOG = 20000;
  localparam int DRAIN    = 24;   // covers the pipeline registers plus the output queue

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic pix_valid = 1'b0;
  logic pix_ready;
  pix_t pix_data = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res_data;

  despill_edge_cleanup_filter dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .pix_valid(pix_valid), .pix_ready(pix_ready), .pix_data(pix_data),
    .res_valid(res_valid), .res_ready(res_ready), .res_data(res_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Shadow copy of the configuration and of the filter state.
  logic [7:0] key_r = 8'd0, key_g = 8'd255, key_b = 8'd0;
  logic [6:0] tol = 7'd35;
  logic       strict = 1'b0;
  logic [10:0] cfg_w = 11'd1024;
  logic [12:0] cfg_h = 13'd4096;
  entry_t ring [RING];
  int unsigned pos = 0, fw = 1, fh = 1;
  logic [CNT_W-1:0] mod_total = '0;

  res_t expected_pixels[$];
  int unsigned errors = 0;
  int unsigned beats_in = 0, beats_out = 0, frames_sent = 0;
  bit hold_req = 1'b0;
  int unsigned idle_cycles = 0;

  function automatic entry_t fetch(int unsigned idx);
    return ring[idx % RING];
  endfunction

  function automatic longint unsigned key_dist(entry_t e);
    int dr, dg, db;
    dr = int'(e.r) - int'(key_r);
    dg = int'(e.g) - int'(key_g);
    db = int'(e.b) - int'(key_b);
    return longint'(dr * dr + dg * dg + db * db);
  endfunction

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned top);
    if (v < 1) return 1;
    if (v > top) return top;
    return v;
  endfunction

  // Advance the shadow filter by one beat; queue a result when one falls out.
  task automatic despill_predict(pix_t d);
    int unsigned npix, delay, c, cx, cy;
    entry_t p, np, best_px;
    longint unsigned thr, best, dd, t;
    bit brd, found;
    logic [31:0] pix_out;
    bit chg;
    int nx, ny;
    res_t r;
    if (pos == 0) begin
      fw = clamp_dim(cfg_w, MAX_WIDTH);
      fh = clamp_dim(cfg_h, MAX_HEIGHT);
    end
    npix = fw * fh;
    delay = 2 * fw + 2;
    if (pos < npix)
      ring[pos % RING] = d.flush ? '0 :
        {d.in_region, d.pix_alpha, d.pix_red, d.pix_green, d.pix_blue};
    if (pos < delay) begin
      pos++;
      return;
    end
    c = pos - delay;
    cy = c / fw;
    cx = c % fw;
    p = fetch(c);
    pix_out = {p.a, p.r, p.g, p.b};
    chg = 1'b0;
    t = longint'(tol) * SCALE_NUM;
    thr = t * t;
    if (p.region && p.a != 0) begin
      brd = cx == 0 || cy == 0 || cx == fw - 1 || cy == fh - 1 ||
            fetch(c - 1).a == 0 || fetch(c + 1).a == 0 ||
            fetch(c - fw).a == 0 || fetch(c + fw).a == 0;
      if (brd && key_dist(p) * SCALE_DEN2 <= thr) begin
        chg = 1'b1;
        if (strict) begin
          pix_out = '0;
        end else begin
          found = 1'b0;
          best = 0;
          best_px = '0;
          for (int dy = -WINDOW_RADIUS; dy <= WINDOW_RADIUS; dy++) begin
            for (int dx = -WINDOW_RADIUS; dx <= WINDOW_RADIUS; dx++) begin
              nx = int'(cx) + dx;
              ny = int'(cy) + dy;
              if (dx == 0 && dy == 0) continue;
              if (nx < 0 || ny < 0 || nx >= int'(fw) || ny >= int'(fh)) continue;
              np = fetch(ny * fw + nx);
              if (np.a <= OPAQUE_MIN) continue;
              dd = key_dist(np);
              if (!found || dd > best) begin
                found = 1'b1;
                best = dd;
                best_px = np;
              end
            end
          end
          if (found && best * SCALE_DEN2 > thr)
            pix_out = {p.a, best_px.r, best_px.g, best_px.b};
          else
            pix_out = '0;
        end
        if (mod_total != COUNT_MAX) mod_total++;
      end
    end
    r.out_alpha = pix_out[31:24];
    r.out_red = pix_out[23:16];
    r.out_green = pix_out[15:8];
    r.out_blue = pix_out[7:0];
    r.changed = chg;
    r.frame_end = (c == npix - 1);
    r.modified_count = mod_total;
    expected_pixels.push_back(r);
    if (r.frame_end) begin
      pos = 0;
      mod_total = '0;
    end else begin
      pos++;
    end
  endtask

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("mismatch on result %0d: %s got %0d, expected %0d", beats_out, what, got, want);
    errors++;
  endtask

  // Check every result beat against the oldest prediction.
  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && res_ready) begin
      if (expected_pixels.size() == 0) begin
        report("unexpected beat", 1, 0);
      end else begin
        want = expected_pixels.pop_front();
        if (res_data.out_alpha !== want.out_alpha) report("alpha", res_data.out_alpha, want.out_alpha);
        if (res_data.out_red !== want.out_red) report("red", res_data.out_red, want.out_red);
        if (res_data.out_green !== want.out_green) report("green", res_data.out_green, want.out_green);
        if (res_data.out_blue !== want.out_blue) report("blue", res_data.out_blue, want.out_blue);
        if (res_data.changed !== want.changed) report("changed", res_data.changed, want.changed);
        if (res_data.frame_end !== want.frame_end)
          report("frame_end", res_data.frame_end, want.frame_end);
        if (res_data.modified_count !== want.modified_count)
          report("modified_count", res_data.modified_count, want.modified_count);
      end
      beats_out++;
    end
  end

  // Mostly no gap, often a short one, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold_req && hold == 0) begin
        hold = 400;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        res_ready <= 1'b0;
      end else if (beats_out % 300 < 80) begin
        res_ready <= 1'b1;       // stretch with no stalls
      end else begin
        res_ready <= (pick_gap() == 0);
      end
    end
  end

  // End the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((pix_valid && pix_ready) || (res_valid && res_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("timeout with %0d results pending", expected_pixels.size());
      $display("simulation failed");
      $finish;
    end
  end

  // Offer one beat, hold it until taken, then maybe drop valid for a gap.
  task automatic send_beat(pix_t d);
    int unsigned gap;
    pix_valid <= 1'b1;
    pix_data <= d;
    do @(posedge clk); while (!pix_ready);
    despill_predict(d);
    beats_in++;
    gap = pick_gap();
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    pix_valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic apb_write(reg_idx_t idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * int'(idx));
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_FRINGE_RED:   key_r = val[7:0];
      REG_FRINGE_GREEN: key_g = val[7:0];
      REG_FRINGE_BLUE:  key_b = val[7:0];
      REG_TOLERANCE:    tol = val[6:0];
      REG_DESPILL_MODE: strict = val[0];
      REG_IMAGE_WIDTH:  cfg_w = val[10:0];
      default:          cfg_h = val[12:0];
    endcase
    @(posedge clk);
  endtask

  task automatic set_key(int unsigned r, int unsigned g, int unsigned b);
    apb_write(REG_FRINGE_RED, r);
    apb_write(REG_FRINGE_GREEN, g);
    apb_write(REG_FRINGE_BLUE, b);
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h);
    apb_write(REG_IMAGE_WIDTH, w);
    apb_write(REG_IMAGE_HEIGHT, h);
  endtask

  function automatic logic [7:0] near(logic [7:0] base);
    int v;
    v = int'(base) + int'($urandom_range(0, 24)) - 12;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // Pixel content: holes, key-coloured fringe, opaque foreground, noise.
  function automatic pix_t make_pixel(bit scene);
    pix_t d;
    int unsigned k;
    d = pix_t'({$urandom, 2'($urandom)});
    d.flush = ($urandom_range(0, 99) < 3);
    d.in_region = ($urandom_range(0, 9) != 0);
    if (scene) begin
      k = $urandom_range(0, 99);
      if (k < 20) begin
        d.pix_alpha = 8'd0;
      end else if (k < 60) begin
        d.pix_red = near(key_r);
        d.pix_green = near(key_g);
        d.pix_blue = near(key_b);
        if (k < 30) d.pix_alpha = 8'd255;
      end else if (k < 90) begin
        d.pix_alpha = 8'($urandom_range(129, 255));
      end
      if (k % 7 == 0) d.pix_alpha = OPAQUE_MIN;
    end
    return d;
  endfunction

  // Send a whole frame with its drain beats, using the size it will latch.
  task automatic run_frame(bit scene);
    int unsigned w, h;
    pix_t d;
    w = clamp_dim(cfg_w, MAX_WIDTH);
    h = clamp_dim(cfg_h, MAX_HEIGHT);
    for (int unsigned i = 0; i < w * h; i++) send_beat(make_pixel(scene));
    for (int unsigned i = 0; i < 2 * w + 2; i++) begin
      d = pix_t'({$urandom, 2'($urandom)});
      d.flush = ($urandom_range(0, 9) != 0);   // a pixel here is dropped
      send_beat(d);
    end
    frames_sent++;
  endtask

  task automatic test_defaults();
    set_geometry(6, 5);
    run_frame(1'b1);
    run_frame(1'b1);
    wait_drained();
  endtask

  task automatic test_geometry_extremes();
    set_geometry(1, 1);
    run_frame(1'b1);
    wait_drained();
    set_geometry(0, 0);        // zero counts as one
    run_frame(1'b1);
    wait_drained();
    set_geometry(5, 3);
    run_frame(1'b0);
    wait_drained();
  endtask

  task automatic test_strict_removal();
    apb_write(REG_DESPILL_MODE, 1);
    set_key(255, 0, 255);
    apb_write(REG_TOLERANCE, 100);
    set_geometry(7, 6);
    run_frame(1'b1);
    wait_drained();
    apb_write(REG_TOLERANCE, 0);   // only an exact key colour matches
    run_frame(1'b1);
    wait_drained();
  endtask

  task automatic test_clamp_recolor();
    apb_write(REG_DESPILL_MODE, 0);
    set_key(0, 0, 0);
    apb_write(REG_TOLERANCE, 127);
    set_geometry(8, 5);
    run_frame(1'b1);
    wait_drained();
    set_key(255, 255, 255);
    apb_write(REG_TOLERANCE, 1);
    run_frame(1'b1);
    wait_drained();
  endtask

  task automatic test_backpressure();
    set_geometry(16, 8);
    hold_req = 1'b1;
    run_frame(1'b1);
    wait_drained();
  endtask

  task automatic test_random_frames();
    int unsigned stop_at;
    stop_at = beats_in + 850;
    while (beats_in < stop_at) begin
      if ($urandom_range(0, 3) == 0) set_key($urandom_range(0, 255),
        $urandom_range(0, 255), $urandom_range(0, 255));
      apb_write(REG_TOLERANCE, $urandom_range(1, 100));
      apb_write(REG_DESPILL_MODE, $urandom_range(0, 1));
      set_geometry($urandom_range(1, 12), $urandom_range(1, 10));
      repeat ($urandom_range(1, 3)) run_frame($urandom_range(0, 9) != 0);
      wait_drained();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_geometry_extremes();
    test_strict_removal();
    test_clamp_recolor();
    test_backpressure();
    test_random_frames();
    $display("covered %0d frames: %0d pixel beats in, %0d results checked", frames_sent,
             beats_in, beats_out);
    $display("both modes, tolerance and size extremes, flush and drain noise, long stall");
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_pixels.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
